### rtl/yuv2rgb_pkg.sv
// Types and constants shared by the 4:2:2 to RGB converter.
package yuv2rgb_pkg;

	// Fixed-point coefficients, 10 fractional bits
	localparam int unsigned FracBits   = 10;
	localparam int unsigned ProdWidth  = 20;
	localparam int unsigned TermWidth  = 9;
	localparam int unsigned SumWidth   = 11;
	localparam logic signed [ProdWidth-1:0] CoefCrRed   = 20'sd1436;
	localparam logic signed [ProdWidth-1:0] CoefCbGreen = 20'sd352;
	localparam logic signed [ProdWidth-1:0] CoefCrGreen = 20'sd731;
	localparam logic signed [ProdWidth-1:0] CoefCbBlue  = 20'sd1815;
	localparam logic [7:0] ChanMax = 8'd255;

	// One packed 4:2:2 group
	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} pix_pair_t;

	// Two pixels in file byte order
	typedef struct packed {
		logic [7:0] first_green;
		logic [7:0] first_red;
		logic [7:0] first_blue;
		logic [7:0] second_green;
		logic [7:0] second_red;
		logic [7:0] second_blue;
	} rgb_pair_t;

	// Chroma contributions shared by both pixels
	typedef struct packed {
		logic signed [TermWidth-1:0] red;
		logic signed [TermWidth-1:0] green;
		logic signed [TermWidth-1:0] blue;
	} chroma_terms_t;

	// Clamped channels of one pixel
	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} rgb_pix_t;

endpackage

### rtl/yuv2rgb_chroma.sv
// Chroma term unit: constant products of both chroma values, floored by 10 bits.
module yuv2rgb_chroma (
	input  logic [7:0]                   chroma_blue,
	input  logic [7:0]                   chroma_red,
	output yuv2rgb_pkg::chroma_terms_t   terms
);

	logic signed [7:0] cb;
	logic signed [7:0] cr;
	logic signed [yuv2rgb_pkg::ProdWidth-1:0] prod_red;
	logic signed [yuv2rgb_pkg::ProdWidth-1:0] prod_cb_green;
	logic signed [yuv2rgb_pkg::ProdWidth-1:0] prod_cr_green;
	logic signed [yuv2rgb_pkg::ProdWidth-1:0] prod_blue;
	logic signed [yuv2rgb_pkg::TermWidth-1:0] green_cb;
	logic signed [yuv2rgb_pkg::TermWidth-1:0] green_cr;
	logic signed [yuv2rgb_pkg::TermWidth:0]   green_sum;

	// Removing the 128 bias is a flip of the top bit
	assign cb = $signed({~chroma_blue[7], chroma_blue[6:0]});
	assign cr = $signed({~chroma_red[7], chroma_red[6:0]});

	// Constant multiplies
	assign prod_red      = yuv2rgb_pkg::ProdWidth'(cr) * yuv2rgb_pkg::CoefCrRed;
	assign prod_cb_green = yuv2rgb_pkg::ProdWidth'(cb) * yuv2rgb_pkg::CoefCbGreen;
	assign prod_cr_green = yuv2rgb_pkg::ProdWidth'(cr) * yuv2rgb_pkg::CoefCrGreen;
	assign prod_blue     = yuv2rgb_pkg::ProdWidth'(cb) * yuv2rgb_pkg::CoefCbBlue;

	// Dropping the fraction bits of a two's complement value floors it
	assign green_cb  = prod_cb_green[yuv2rgb_pkg::FracBits +: yuv2rgb_pkg::TermWidth];
	assign green_cr  = prod_cr_green[yuv2rgb_pkg::FracBits +: yuv2rgb_pkg::TermWidth];
	assign green_sum = (yuv2rgb_pkg::TermWidth+1)'(green_cb)
		+ (yuv2rgb_pkg::TermWidth+1)'(green_cr);

	// Green sum stays within -136..133
	assign terms.red   = prod_red[yuv2rgb_pkg::FracBits +: yuv2rgb_pkg::TermWidth];
	assign terms.green = green_sum[yuv2rgb_pkg::TermWidth-1:0];
	assign terms.blue  = prod_blue[yuv2rgb_pkg::FracBits +: yuv2rgb_pkg::TermWidth];

endmodule

### rtl/yuv2rgb_lane.sv
// Pixel lane: adds the red and blue chroma terms to one luma value, subtracts the green term, and clamps each channel.
module yuv2rgb_lane (
	input  logic [7:0]                 luma,
	input  yuv2rgb_pkg::chroma_terms_t terms,
	output yuv2rgb_pkg::rgb_pix_t      pix
);

	logic signed [yuv2rgb_pkg::SumWidth-1:0] y_ext;
	logic signed [yuv2rgb_pkg::SumWidth-1:0] sum_green;
	logic signed [yuv2rgb_pkg::SumWidth-1:0] sum_red;
	logic signed [yuv2rgb_pkg::SumWidth-1:0] sum_blue;

	function automatic logic [7:0] clamp8(input logic signed [yuv2rgb_pkg::SumWidth-1:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > $signed(yuv2rgb_pkg::SumWidth'(yuv2rgb_pkg::ChanMax))) begin
			r = yuv2rgb_pkg::ChanMax;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	assign y_ext = $signed({{(yuv2rgb_pkg::SumWidth-8){1'b0}}, luma});

	// Channel sums, range -227..480
	assign sum_green = y_ext - yuv2rgb_pkg::SumWidth'(terms.green);
	assign sum_red   = y_ext + yuv2rgb_pkg::SumWidth'(terms.red);
	assign sum_blue  = y_ext + yuv2rgb_pkg::SumWidth'(terms.blue);

	assign pix.green = clamp8(sum_green);
	assign pix.red   = clamp8(sum_red);
	assign pix.blue  = clamp8(sum_blue);

endmodule

### rtl/yuv422_pair_to_rgb.sv
// Top level: 4:2:2 pair to two RGB pixels, chroma stage then two pixel lanes.
//
//  channel | direction | handshake              | payload
//  pix     | in        | pix_valid / pix_ready  | pix_pair_t (y0, cb, y1, cr)
//  rgb     | out       | rgb_valid / rgb_ready  | rgb_pair_t (g0 r0 b0 g1 r1 b1)
//
// Two register stages: chroma products into _s1, lane sums and clamps into the
// output register. One transfer per cycle in each direction while rgb is not stalled.
// Reset clears only the stage valid bits. A stall on rgb holds the output stage
// and a full stage 1, and a bubble in stage 1 is filled while the output waits.
module yuv422_pair_to_rgb (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid,
	output logic                    pix_ready,
	input  yuv2rgb_pkg::pix_pair_t  pix,
	output logic                    rgb_valid,
	input  logic                    rgb_ready,
	output yuv2rgb_pkg::rgb_pair_t  rgb
);

	yuv2rgb_pkg::chroma_terms_t terms;
	yuv2rgb_pkg::chroma_terms_t terms_s1;
	logic [7:0]                 luma_first_s1;
	logic [7:0]                 luma_second_s1;
	logic                       valid_s1;
	yuv2rgb_pkg::rgb_pix_t      pix_first;
	yuv2rgb_pkg::rgb_pix_t      pix_second;
	yuv2rgb_pkg::rgb_pair_t     rgb_s2;
	logic                       valid_s2;
	logic                       adv_s1;
	logic                       adv_s2;

	// Stage enables
	assign adv_s2    = !valid_s2 || rgb_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pix_ready = adv_s1;

	// Shared chroma unit
	yuv2rgb_chroma u_chroma (
		.chroma_blue (pix.chroma_blue),
		.chroma_red  (pix.chroma_red),
		.terms       (terms)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pix_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) begin
			terms_s1       <= terms;
			luma_first_s1  <= pix.luma_first;
			luma_second_s1 <= pix.luma_second;
		end
	end

	// Pixel lanes
	yuv2rgb_lane u_lane_first (
		.luma  (luma_first_s1),
		.terms (terms_s1),
		.pix   (pix_first)
	);

	yuv2rgb_lane u_lane_second (
		.luma  (luma_second_s1),
		.terms (terms_s1),
		.pix   (pix_second)
	);

	// Output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Merge both lanes into file byte order
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rgb_s2 <= {pix_first.green, pix_first.red, pix_first.blue,
				pix_second.green, pix_second.red, pix_second.blue};
		end
	end

	assign rgb_valid = valid_s2;
	assign rgb       = rgb_s2;

`ifndef SYNTH
	// An accepted group always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> valid_s1)
		else $error("accepted group lost before stage 1");

	// A blocked stage 1 keeps its item
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(terms_s1) && $stable(luma_first_s1))
		else $error("stage 1 item dropped during stall");

	// Stage 1 moves to the output whenever the output is free
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> rgb_valid)
		else $error("stage 1 item not passed to output");

	// Input is refused only when both stages hold items and output is stalled
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> valid_s1 && rgb_valid && !rgb_ready)
		else $error("input refused with room in the pipeline");
`endif

endmodule
